### hw/rtl/bfba_pkg.sv
// Shared types and constants for the best-fit block allocator.
// Used by the channel interfaces, the block table and the top level.
// No dependencies.
package bfba_pkg;

	localparam int MAX_BLOCKS = 64;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
	localparam int SIZE_W     = 16;
	localparam int BCOUNT_W   = 7;

	localparam logic [BCOUNT_W-1:0] BLOCK_COUNT_RESET = BCOUNT_W'(MAX_BLOCKS);

	typedef enum logic [0:0] {
		CMD_LOAD  = 1'b0,
		CMD_ALLOC = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [SIZE_W-1:0] data;
	} tbl_wr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} tbl_rd_t;

endpackage

### hw/rtl/bfba_if.sv
// Valid/ready channel interfaces of the best-fit block allocator:
// command input, result output and the block count write channel.
// Depends on bfba_pkg.
interface bfba_req_if import bfba_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              command;
	logic [IDX_W-1:0]  block_index;
	logic [SIZE_W-1:0] size;

	modport source (output valid, command, block_index, size, input ready);
	modport sink (input valid, command, block_index, size, output ready);
endinterface

interface bfba_rsp_if import bfba_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              granted;
	logic [IDX_W-1:0]  block_number;
	logic [SIZE_W-1:0] block_size_before;
	logic [SIZE_W-1:0] leftover;

	modport source (output valid, granted, block_number, block_size_before, leftover,
		input ready);
	modport sink (input valid, granted, block_number, block_size_before, leftover,
		output ready);
endinterface

interface bfba_cfg_if import bfba_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [BCOUNT_W-1:0] block_count;

	modport source (output valid, block_count, input ready);
	modport sink (input valid, block_count, output ready);
endinterface

### hw/rtl/bfba_table.sv
// Table of remaining block sizes: one write port, one read port,
// read data registered. Depends on bfba_pkg.
module bfba_table import bfba_pkg::*; (
	input  logic              clk,
	input  tbl_wr_t           wr,
	input  tbl_rd_t           rd,
	output logic [SIZE_W-1:0] rd_data
);

	logic [SIZE_W-1:0] mem [MAX_BLOCKS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

### hw/rtl/best_fit_block_allocator.sv
// Channel  | Dir | Payload                                              | Transaction
// req      | in  | command, block_index, size                           | valid & ready
// rsp      | out | granted, block_number, block_size_before, leftover   | valid & ready
// cfg      | in  | block_count                                          | valid & ready
//
// A load writes the table and goes to ST_FINISH. An allocation runs ST_SCAN, ST_DRAIN,
// ST_WRITE, ST_FINISH; the scan reads one table entry per cycle through the single
// read port of bfba_table. A block count of zero skips ST_SCAN and ST_DRAIN.
// One command is processed at a time; req.ready is high only while idle.
// The result register frees the engine unless a previous result is still unaccepted.
// Reset clears control state only; table entries are undefined until loaded.
module best_fit_block_allocator import bfba_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	bfba_req_if.sink   req,
	bfba_rsp_if.source rsp,
	bfba_cfg_if.sink   cfg
);

	state_t              state_q, state_d;
	logic [BCOUNT_W-1:0] block_count_q;
	logic [CNT_W-1:0]    limit;
	logic [CNT_W-1:0]    scan_idx_q;
	logic                scan_last;
	logic                req_fire;
	logic                rsp_load;

	logic [SIZE_W-1:0]   req_sz_q;
	logic                cmp_valid_s1;
	logic [IDX_W-1:0]    cmp_idx_s1;
	logic                found_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic [SIZE_W-1:0]   best_before_q;
	logic [SIZE_W-1:0]   best_left_q;
	logic                fits;
	logic [SIZE_W-1:0]   left;
	logic                take;

	logic                rsp_valid_q;
	logic                granted_q;
	logic [IDX_W-1:0]    block_number_q;
	logic [SIZE_W-1:0]   before_q;
	logic [SIZE_W-1:0]   leftover_q;

	tbl_wr_t             tbl_wr;
	tbl_rd_t             tbl_rd;
	logic [SIZE_W-1:0]   tbl_rd_data;

	bfba_table u_table (
		.clk     (clk),
		.wr      (tbl_wr),
		.rd      (tbl_rd),
		.rd_data (tbl_rd_data)
	);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= BLOCK_COUNT_RESET;
		end else if (cfg.valid) begin
			block_count_q <= cfg.block_count;
		end
	end

	// Counts above the table depth scan the whole table.
	assign limit = (block_count_q > BCOUNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
		: CNT_W'(block_count_q);
	assign scan_last = (CNT_W'(scan_idx_q + CNT_W'(1)) == limit);
	assign req_fire  = req.valid && req.ready;
	assign rsp_load  = (state_q == ST_FINISH) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		req.ready   = 1'b0;
		tbl_rd.en   = 1'b0;
		tbl_rd.addr = scan_idx_q[IDX_W-1:0];
		tbl_wr.en   = 1'b0;
		tbl_wr.addr = req.block_index;
		tbl_wr.data = req.size;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.command == CMD_LOAD) begin
						tbl_wr.en = 1'b1;
						state_d   = ST_FINISH;
					end else if (limit == '0) begin
						state_d = ST_WRITE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				tbl_rd.en = 1'b1;
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				tbl_wr.en   = found_q;
				tbl_wr.addr = best_idx_q;
				tbl_wr.data = best_left_q;
				state_d     = ST_FINISH;
			end
			ST_FINISH: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign fits = (tbl_rd_data >= req_sz_q);
	assign left = tbl_rd_data - req_sz_q;
	// Less-or-equal lets the later block win a tie.
	assign take = cmp_valid_s1 && fits && (!found_q || (left <= best_left_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q   <= '0;
			cmp_valid_s1 <= 1'b0;
			found_q      <= 1'b0;
		end else begin
			cmp_valid_s1 <= (state_q == ST_SCAN);
			if (req_fire) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
			end else begin
				if (state_q == ST_SCAN) begin
					scan_idx_q <= CNT_W'(scan_idx_q + CNT_W'(1));
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_sz_q <= req.size;
		end
		if (state_q == ST_SCAN) begin
			cmp_idx_s1 <= scan_idx_q[IDX_W-1:0];
		end
		if (take) begin
			best_idx_q    <= cmp_idx_s1;
			best_before_q <= tbl_rd_data;
			best_left_q   <= left;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			granted_q      <= found_q;
			block_number_q <= found_q ? best_idx_q : '0;
			before_q       <= found_q ? best_before_q : '0;
			leftover_q     <= found_q ? best_left_q : '0;
		end
	end

	assign rsp.valid             = rsp_valid_q;
	assign rsp.granted           = granted_q;
	assign rsp.block_number      = block_number_q;
	assign rsp.block_size_before = before_q;
	assign rsp.leftover          = leftover_q;

`ifndef SYNTHESIS
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_DRAIN) |-> !tbl_wr.en)
		else $error("table written while a scan is in progress");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (scan_idx_q < limit))
		else $error("scan index beyond the block count");

	a_grant_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && found_q) |->
		(SIZE_W'(best_before_q - best_left_q) == req_sz_q))
		else $error("granted block does not match the request size");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == ST_FINISH))
		else $error("result loaded outside the finish state");
`endif

endmodule

### sim/bfba_checker.sv
// Result checker for the best-fit block allocator: mirrors the block table,
// predicts one result per accepted command and compares it with the rsp channel.
// Depends on bfba_pkg and the channel interfaces in bfba_if.sv.
`timescale 1ns / 100ps

module bfba_checker import bfba_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	bfba_req_if        req,
	bfba_rsp_if        rsp,
	bfba_cfg_if        cfg,
	output int         pending,
	output int         failures,
	output int         grants
);

	typedef struct packed {
		logic              granted;
		logic [IDX_W-1:0]  block_number;
		logic [SIZE_W-1:0] size_before;
		logic [SIZE_W-1:0] leftover;
	} grant_t;

	logic [SIZE_W-1:0]   block_left [MAX_BLOCKS];
	logic [BCOUNT_W-1:0] scan_count;
	grant_t              awaited[$];
	int                  fail_tally;
	int                  grant_tally;

	// Applies one command to the mirrored table and returns the result it must produce.
	function automatic grant_t apply_command(cmd_t c, logic [IDX_W-1:0] idx,
		logic [SIZE_W-1:0] sz);
		grant_t            g;
		int                limit;
		bit                found;
		logic [SIZE_W-1:0] best_left;
		g = '0;
		found = 1'b0;
		best_left = '0;
		if (c == CMD_LOAD) begin
			block_left[idx] = sz;
			return g;
		end
		limit = (scan_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(scan_count);
		// The comparison is "less or equal" so that a later block wins a tie.
		for (int k = 0; k < limit; k++) begin
			if (block_left[k] >= sz && (!found || block_left[k] - sz <= best_left)) begin
				found = 1'b1;
				best_left = block_left[k] - sz;
				g.block_number = IDX_W'(k);
				g.size_before = block_left[k];
			end
		end
		if (found) begin
			g.granted = 1'b1;
			g.leftover = best_left;
			block_left[g.block_number] = best_left;
		end else begin
			g = '0;
		end
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			scan_count = BLOCK_COUNT_RESET;
			awaited.delete();
			fail_tally = 0;
			grant_tally = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				scan_count = cfg.block_count;
			// A result accepted at this edge always belongs to an older command,
			// so the comparison comes before the new expectation is queued.
			if (rsp.valid && rsp.ready) begin
				if (awaited.size() == 0) begin
					$error("result transaction with no command waiting for it");
					fail_tally++;
				end else begin
					want = awaited.pop_front();
					if (rsp.granted !== want.granted) begin
						$error("granted: expected %0d, got %0d", want.granted, rsp.granted);
						fail_tally++;
					end
					if (rsp.block_number !== want.block_number) begin
						$error("block_number: expected %0d, got %0d",
							want.block_number, rsp.block_number);
						fail_tally++;
					end
					if (rsp.block_size_before !== want.size_before) begin
						$error("block_size_before: expected %0d, got %0d",
							want.size_before, rsp.block_size_before);
						fail_tally++;
					end
					if (rsp.leftover !== want.leftover) begin
						$error("leftover: expected %0d, got %0d",
							want.leftover, rsp.leftover);
						fail_tally++;
					end
					if (want.granted)
						grant_tally++;
				end
			end
			if (req.valid && req.ready)
				awaited.push_back(apply_command(cmd_t'(req.command), req.block_index,
					req.size));
		end
		pending <= awaited.size();
		failures <= fail_tally;
		grants <= grant_tally;
	end

endmodule

### sim/tb_best_fit_block_allocator.sv
// Top of the best-fit block allocator testbench: clock, reset, command and
// block count stimulus, result back-pressure and the final verdict.
// Depends on bfba_pkg, bfba_if.sv, the allocator RTL and bfba_checker.
`timescale 1ns / 100ps

module tb_best_fit_block_allocator import bfba_pkg::*; ();

	logic clk;
	logic arst_n;

	bfba_req_if req_ch();
	bfba_rsp_if rsp_ch();
	bfba_cfg_if cfg_ch();

	int pending;
	int fail_count;
	int grant_count;
	bit quiet;
	bit long_hold;
	bit loaded [MAX_BLOCKS];
	int active_limit;
	int load_count;
	int alloc_count;
	int setting_count;

	best_fit_block_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	bfba_checker result_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg      (cfg_ch),
		.pending  (pending),
		.failures (fail_count),
		.grants   (grant_count)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Mostly short gaps, now and then a long one; none at all in a quiet phase.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [SIZE_W-1:0] block_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '1;
		if (r < 10)
			return '0;
		if (r < 30)
			return SIZE_W'($urandom);
		if (r < 45)
			return SIZE_W'(100 * $urandom_range(1, 3));
		return SIZE_W'($urandom_range(0, 4000));
	endfunction

	function automatic logic [SIZE_W-1:0] request_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 10)
			return '1;
		if (r < 25)
			return SIZE_W'($urandom);
		if (r < 40)
			return SIZE_W'(100 * $urandom_range(1, 3));
		return SIZE_W'($urandom_range(0, 1500));
	endfunction

	task automatic send_item(cmd_t c, logic [IDX_W-1:0] idx, logic [SIZE_W-1:0] sz);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= c;
		req_ch.block_index <= idx;
		req_ch.size <= sz;
		do @(posedge clk); while (!req_ch.ready);
		if (c == CMD_LOAD) begin
			loaded[idx] = 1'b1;
			load_count++;
		end else begin
			alloc_count++;
		end
	endtask

	// The block is idle once every issued command has had its result taken.
	task automatic settle(int tail);
		req_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_count(logic [BCOUNT_W-1:0] v);
		settle(8);
		cfg_ch.valid <= 1'b1;
		cfg_ch.block_count <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		active_limit = (v > MAX_BLOCKS) ? MAX_BLOCKS : int'(v);
		setting_count++;
	endtask

	// Loads every block that the next allocations will scan before any of them
	// is issued, then mixes loads and allocations.
	task automatic random_phase(logic [BCOUNT_W-1:0] v, int n, bit hold);
		logic [IDX_W-1:0] idx;
		write_count(v);
		quiet = ($urandom_range(0, 3) == 0);
		if (hold || $urandom_range(0, 2) == 0)
			long_hold = 1'b1;
		for (int k = 0; k < active_limit; k++)
			if (!loaded[k])
				send_item(CMD_LOAD, IDX_W'(k), block_size());
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 35) begin
				if (active_limit > 0 && $urandom_range(0, 3) != 0)
					idx = IDX_W'($urandom_range(0, active_limit - 1));
				else
					idx = IDX_W'($urandom_range(0, MAX_BLOCKS - 1));
				send_item(CMD_LOAD, idx, block_size());
			end else begin
				send_item(CMD_ALLOC, IDX_W'($urandom), request_size());
			end
		end
	endtask

	// Result side: random back-pressure, with one long hold-off on request.
	initial begin
		int n;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (long_hold) begin
				rsp_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
				long_hold = 1'b0;
			end else begin
				n = pick_gap();
				if (n > 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
				rsp_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	initial begin
		#15_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_LOAD;
		req_ch.block_index = '0;
		req_ch.size = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.block_count = '0;
		quiet = 1'b0;
		long_hold = 1'b0;
		active_limit = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Loads under the reset block count; no allocation may scan yet.
		send_item(CMD_LOAD, 6'd0, 16'd100);
		send_item(CMD_LOAD, 6'd1, 16'd50);
		send_item(CMD_LOAD, 6'd2, 16'd50);
		send_item(CMD_LOAD, 6'd3, 16'hFFFF);
		send_item(CMD_LOAD, 6'd63, 16'hFFFF);
		send_item(CMD_LOAD, 6'd42, 16'hAAAA);
		send_item(CMD_LOAD, 6'd21, 16'h5555);

		// With no block in use every allocation fails.
		write_count(7'd0);
		send_item(CMD_ALLOC, 6'd0, 16'd0);
		send_item(CMD_ALLOC, 6'h3F, 16'hFFFF);

		// Ties, exact fits, a request of zero and requests that fit nowhere.
		write_count(7'd4);
		send_item(CMD_ALLOC, 6'd0, 16'd50);
		send_item(CMD_ALLOC, 6'd0, 16'd50);
		send_item(CMD_ALLOC, 6'd0, 16'd0);
		send_item(CMD_ALLOC, 6'd0, 16'hFFFF);
		send_item(CMD_ALLOC, 6'd0, 16'hFFFF);
		send_item(CMD_ALLOC, 6'd0, 16'd101);
		send_item(CMD_ALLOC, 6'd0, 16'd100);
		send_item(CMD_ALLOC, 6'd0, 16'd1);

		random_phase(7'd64, 75, 1'b1);
		random_phase(7'd127, 75, 1'b0);
		random_phase(7'd1, 75, 1'b0);
		random_phase(7'd0, 60, 1'b0);
		random_phase(BCOUNT_W'($urandom_range(2, 63)), 75, 1'b0);
		random_phase(BCOUNT_W'($urandom_range(65, 126)), 75, 1'b0);
		random_phase(7'd64, 75, 1'b0);
		random_phase(BCOUNT_W'($urandom_range(2, 63)), 75, 1'b0);

		settle(70);
		$display("Ran %0d loads and %0d allocations, %0d of them granted,",
			load_count, alloc_count, grant_count);
		$display("across %0d block counts including 0, 1, 64 and 127.", setting_count);
		if (fail_count == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
